/* rtl/core/lsft_pkg.sv */
`timescale 1ns / 1ps

package lsft_pkg;

    // Default storage widths
    localparam int TIME_WIDTH_DEF  = 32;
    localparam int FLOOR_WIDTH_DEF = 8;

    // Fixed field widths
    localparam int OP_W        = 3;
    localparam int MOTION_W    = 3;
    localparam int FLOOR_OUT_W = 8;
    localparam int DIR_W       = 2;
    localparam int CLOSE_W     = 8;
    localparam int TIME_OUT_W  = 32;

    // Operation codes
    localparam logic [OP_W-1:0] OP_UP_EDGE   = 3'd0;
    localparam logic [OP_W-1:0] OP_DOWN_EDGE = 3'd1;
    localparam logic [OP_W-1:0] OP_DOOR_EDGE = 3'd2;
    localparam logic [OP_W-1:0] OP_SETTLED   = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK      = 3'd4;

    // Direction codes
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_LEVEL = 2'd2;

    // Reported motion codes
    localparam logic [MOTION_W-1:0] MC_LVL_STATIC = 3'd0;
    localparam logic [MOTION_W-1:0] MC_LVL_MOVING = 3'd1;
    localparam logic [MOTION_W-1:0] MC_RISE1      = 3'd2;
    localparam logic [MOTION_W-1:0] MC_RISE2      = 3'd3;
    localparam logic [MOTION_W-1:0] MC_RISE3      = 3'd4;
    localparam logic [MOTION_W-1:0] MC_FALL1      = 3'd5;
    localparam logic [MOTION_W-1:0] MC_FALL2      = 3'd6;
    localparam logic [MOTION_W-1:0] MC_FALL3      = 3'd7;

    // Rise and fall sequence, one-hot
    typedef enum logic [7:0] {
        M_LVL_STATIC = 8'b0000_0001,
        M_LVL_MOVING = 8'b0000_0010,
        M_RISE1      = 8'b0000_0100,
        M_RISE2      = 8'b0000_1000,
        M_RISE3      = 8'b0001_0000,
        M_FALL1      = 8'b0010_0000,
        M_FALL2      = 8'b0100_0000,
        M_FALL3      = 8'b1000_0000
    } t_motion;

    typedef struct packed {
        logic [OP_W-1:0] operation;
        logic            up_switch;
        logic            down_switch;
        logic            door_open;
        logic            occupied;
    } t_item;

    typedef struct packed {
        logic [MOTION_W-1:0]    motion_state;
        logic [FLOOR_OUT_W-1:0] floor;
        logic [DIR_W-1:0]       direction;
        logic [CLOSE_W-1:0]     door_close_count;
        logic                   fault_moving_door_open;
        logic                   fault_start_door_open;
        logic [TIME_OUT_W-1:0]  travel_time;
        logic                   settle_timer_run;
        logic                   occupancy_timer_run;
        logic                   door_timer_run;
    } t_result;

    // Map the one-hot sequence state to its reported code
    function automatic logic [MOTION_W-1:0] motion_code(input t_motion m);
        logic [MOTION_W-1:0] code;
        case (m)
            M_LVL_STATIC: code = MC_LVL_STATIC;
            M_LVL_MOVING: code = MC_LVL_MOVING;
            M_RISE1:      code = MC_RISE1;
            M_RISE2:      code = MC_RISE2;
            M_RISE3:      code = MC_RISE3;
            M_FALL1:      code = MC_FALL1;
            M_FALL2:      code = MC_FALL2;
            M_FALL3:      code = MC_FALL3;
            default:      code = MC_LVL_STATIC;
        endcase
        return code;
    endfunction

endpackage

/* rtl/core/lsft_in_stage.sv */
`timescale 1ns / 1ps

module lsft_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  lsft_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_valid,
    output lsft_pkg::t_item o_item
);

    logic            r_valid;
    lsft_pkg::t_item r_item;
    logic            w_load;

    // Take a new transfer when empty or when the held item moves on
    assign o_ready = !r_valid || i_advance;
    assign w_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // Hold the payload until replaced
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* rtl/core/lsft_core.sv */
`timescale 1ns / 1ps

module lsft_core #(
    parameter int TIME_WIDTH  = lsft_pkg::TIME_WIDTH_DEF,
    parameter int FLOOR_WIDTH = lsft_pkg::FLOOR_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  lsft_pkg::t_item   i_item,
    output lsft_pkg::t_result o_result
);

    lsft_pkg::t_motion            r_motion, n_motion;
    logic [FLOOR_WIDTH-1:0]       r_floor, n_floor;
    logic [lsft_pkg::DIR_W-1:0]   r_dir, n_dir;
    logic [lsft_pkg::CLOSE_W-1:0] r_closures, n_closures;
    logic                         r_fault_move, n_fault_move;
    logic                         r_fault_start, n_fault_start;
    logic [TIME_WIDTH-1:0]        r_travel_cnt, n_travel_cnt;
    logic                         r_travel_run, n_travel_run;
    logic [TIME_WIDTH-1:0]        r_captured, n_captured;
    logic                         r_settle_run, n_settle_run;
    logic                         r_occ_run, n_occ_run;
    logic                         r_door_run, n_door_run;

    logic w_up, w_down, w_door, w_occ;
    logic w_level;

    assign w_up    = i_item.up_switch;
    assign w_down  = i_item.down_switch;
    assign w_door  = i_item.door_open;
    assign w_occ   = i_item.occupied;
    assign w_level = (r_motion == lsft_pkg::M_LVL_STATIC) ||
                     (r_motion == lsft_pkg::M_LVL_MOVING);

    // Next state for one item
    always_comb begin
        n_motion      = r_motion;
        n_floor       = r_floor;
        n_dir         = r_dir;
        n_closures    = r_closures;
        n_fault_move  = r_fault_move;
        n_fault_start = r_fault_start;
        n_travel_cnt  = r_travel_cnt;
        n_travel_run  = r_travel_run;
        n_captured    = r_captured;
        n_settle_run  = r_settle_run;
        n_occ_run     = r_occ_run;
        n_door_run    = r_door_run;

        case (i_item.operation)
            lsft_pkg::OP_UP_EDGE: begin
                if (w_up) begin
                    if (!w_down && r_motion == lsft_pkg::M_RISE2) begin
                        n_motion = lsft_pkg::M_RISE3;
                    end else if (w_down && r_motion == lsft_pkg::M_FALL3) begin
                        // Floor passed on the way down
                        n_motion     = lsft_pkg::M_LVL_MOVING;
                        n_settle_run = 1'b1;
                        if (r_dir == lsft_pkg::DIR_UP) begin
                            n_floor = r_floor + 1'b1;
                        end else if (r_dir == lsft_pkg::DIR_DOWN) begin
                            n_floor = r_floor - 1'b1;
                        end
                    end
                end else begin
                    if (w_down && (w_level || r_motion == lsft_pkg::M_FALL1)) begin
                        // Leave level upward
                        if (r_motion == lsft_pkg::M_LVL_STATIC && w_door) begin
                            n_fault_start = 1'b1;
                        end
                        n_motion   = lsft_pkg::M_RISE1;
                        n_dir      = lsft_pkg::DIR_UP;
                        n_occ_run  = 1'b0;
                        n_closures = '0;
                    end else if (!w_down && r_motion == lsft_pkg::M_FALL1) begin
                        n_settle_run = 1'b0;
                        n_motion     = lsft_pkg::M_FALL2;
                    end
                end
            end
            lsft_pkg::OP_DOWN_EDGE: begin
                if (w_down) begin
                    if (w_up && r_motion == lsft_pkg::M_RISE3) begin
                        // Floor passed on the way up; capture travel time
                        n_motion     = lsft_pkg::M_LVL_MOVING;
                        n_settle_run = 1'b1;
                        n_travel_run = 1'b0;
                        n_captured   = r_travel_cnt;
                        if (r_dir == lsft_pkg::DIR_UP) begin
                            n_floor = r_floor + 1'b1;
                        end else if (r_dir == lsft_pkg::DIR_DOWN) begin
                            n_floor = r_floor - 1'b1;
                        end
                    end else if (!w_up && r_motion == lsft_pkg::M_FALL2) begin
                        n_travel_run = 1'b0;
                        n_captured   = r_travel_cnt;
                        n_motion     = lsft_pkg::M_FALL3;
                    end
                end else begin
                    if (!w_up && r_motion == lsft_pkg::M_RISE1) begin
                        n_settle_run = 1'b0;
                        n_travel_cnt = '0;
                        n_travel_run = 1'b1;
                        n_motion     = lsft_pkg::M_RISE2;
                    end else if (w_up && (w_level || r_motion == lsft_pkg::M_RISE1)) begin
                        // Leave level downward and start timing
                        n_travel_cnt = '0;
                        n_travel_run = 1'b1;
                        if (r_motion == lsft_pkg::M_LVL_STATIC && w_door) begin
                            n_fault_start = 1'b1;
                        end
                        n_motion   = lsft_pkg::M_FALL1;
                        n_dir      = lsft_pkg::DIR_DOWN;
                        n_occ_run  = 1'b0;
                        n_closures = '0;
                    end
                end
            end
            lsft_pkg::OP_DOOR_EDGE: begin
                if (!w_door) begin
                    n_door_run = 1'b0;
                    if (r_dir == lsft_pkg::DIR_LEVEL) begin
                        n_closures = r_closures + 1'b1;
                        if (w_occ) begin
                            n_occ_run = 1'b1;
                        end
                    end
                end else begin
                    n_door_run = 1'b1;
                    n_occ_run  = 1'b0;
                    if (r_dir == lsft_pkg::DIR_UP || r_dir == lsft_pkg::DIR_DOWN) begin
                        n_fault_move = 1'b1;
                    end
                end
            end
            lsft_pkg::OP_SETTLED: begin
                n_motion = lsft_pkg::M_LVL_STATIC;
                n_dir    = lsft_pkg::DIR_LEVEL;
            end
            lsft_pkg::OP_TICK: begin
                if (r_travel_run) begin
                    n_travel_cnt = r_travel_cnt + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Commit state when the item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion      <= lsft_pkg::M_LVL_STATIC;
            r_floor       <= '0;
            r_dir         <= lsft_pkg::DIR_LEVEL;
            r_closures    <= '0;
            r_fault_move  <= 1'b0;
            r_fault_start <= 1'b0;
            r_travel_cnt  <= '0;
            r_travel_run  <= 1'b0;
            r_captured    <= '0;
            r_settle_run  <= 1'b0;
            r_occ_run     <= 1'b0;
            r_door_run    <= 1'b0;
        end else if (i_advance) begin
            r_motion      <= n_motion;
            r_floor       <= n_floor;
            r_dir         <= n_dir;
            r_closures    <= n_closures;
            r_fault_move  <= n_fault_move;
            r_fault_start <= n_fault_start;
            r_travel_cnt  <= n_travel_cnt;
            r_travel_run  <= n_travel_run;
            r_captured    <= n_captured;
            r_settle_run  <= n_settle_run;
            r_occ_run     <= n_occ_run;
            r_door_run    <= n_door_run;
        end
    end

    // Report the state after the update
    always_comb begin
        o_result.motion_state           = lsft_pkg::motion_code(n_motion);
        o_result.floor                  = lsft_pkg::FLOOR_OUT_W'(n_floor);
        o_result.direction              = n_dir;
        o_result.door_close_count       = n_closures;
        o_result.fault_moving_door_open = n_fault_move;
        o_result.fault_start_door_open  = n_fault_start;
        o_result.travel_time            = lsft_pkg::TIME_OUT_W'(n_captured);
        o_result.settle_timer_run       = n_settle_run;
        o_result.occupancy_timer_run    = n_occ_run;
        o_result.door_timer_run         = n_door_run;
    end

endmodule

/* rtl/core/lsft_out_stage.sv */
`timescale 1ns / 1ps

module lsft_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  lsft_pkg::t_result i_result,
    output logic              o_valid,
    input  logic              i_ready,
    output lsft_pkg::t_result o_result
);

    logic              r_valid;
    lsft_pkg::t_result r_result;
    logic              w_load;

    // Accept a result when empty or when the held one is taken
    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* rtl/core/leveling_switch_floor_tracker_top.sv */
`timescale 1ns / 1ps
// Path: each input transfer is held in the input register; its result then passes to
// the result register, from which the consumer takes it.
// Throughput: one item per cycle unless i_out_ready stalls the result register;
// the state update is a single combinational pass from input to result register.
// Reset: i_rst_n synchronous, active low; car level static, direction level,
// counters, faults and timer run flags cleared, both stages empty.

module leveling_switch_floor_tracker_top #(
    parameter int TIME_WIDTH  = lsft_pkg::TIME_WIDTH_DEF,
    parameter int FLOOR_WIDTH = lsft_pkg::FLOOR_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [lsft_pkg::OP_W-1:0]        i_operation,
    input  logic                             i_up_switch,
    input  logic                             i_down_switch,
    input  logic                             i_door_open,
    input  logic                             i_occupied,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [lsft_pkg::MOTION_W-1:0]    o_motion_state,
    output logic [lsft_pkg::FLOOR_OUT_W-1:0] o_floor,
    output logic [lsft_pkg::DIR_W-1:0]       o_direction,
    output logic [lsft_pkg::CLOSE_W-1:0]     o_door_close_count,
    output logic                             o_fault_moving_door_open,
    output logic                             o_fault_start_door_open,
    output logic [lsft_pkg::TIME_OUT_W-1:0]  o_travel_time,
    output logic                             o_settle_timer_run,
    output logic                             o_occupancy_timer_run,
    output logic                             o_door_timer_run
);

    lsft_pkg::t_item   w_in_item;
    lsft_pkg::t_item   w_held_item;
    lsft_pkg::t_result w_next_result;
    lsft_pkg::t_result w_out_result;
    logic              w_held_valid;
    logic              w_out_ready;
    logic              w_advance;

    // Gather the input fields
    assign w_in_item.operation   = i_operation;
    assign w_in_item.up_switch   = i_up_switch;
    assign w_in_item.down_switch = i_down_switch;
    assign w_in_item.door_open   = i_door_open;
    assign w_in_item.occupied    = i_occupied;

    // Advance the held item when the result register has room
    assign w_advance = w_held_valid && w_out_ready;

    lsft_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (w_in_item),
        .i_advance (w_advance),
        .o_valid   (w_held_valid),
        .o_item    (w_held_item)
    );

    lsft_core #(
        .TIME_WIDTH  (TIME_WIDTH),
        .FLOOR_WIDTH (FLOOR_WIDTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (w_held_item),
        .o_result  (w_next_result)
    );

    lsft_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_held_valid),
        .o_ready  (w_out_ready),
        .i_result (w_next_result),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (w_out_result)
    );

    // Split the result onto its ports
    assign o_motion_state           = w_out_result.motion_state;
    assign o_floor                  = w_out_result.floor;
    assign o_direction              = w_out_result.direction;
    assign o_door_close_count       = w_out_result.door_close_count;
    assign o_fault_moving_door_open = w_out_result.fault_moving_door_open;
    assign o_fault_start_door_open  = w_out_result.fault_start_door_open;
    assign o_travel_time            = w_out_result.travel_time;
    assign o_settle_timer_run       = w_out_result.settle_timer_run;
    assign o_occupancy_timer_run    = w_out_result.occupancy_timer_run;
    assign o_door_timer_run         = w_out_result.door_timer_run;

endmodule
